// ===== hw/rtl/quaternion_twist_angle_core_assert.svh =====
// Assertion helpers for the twist angle core
`ifndef QUATERNION_TWIST_ANGLE_CORE_ASSERT_SVH
`define QUATERNION_TWIST_ANGLE_CORE_ASSERT_SVH

// Property that must hold at every clock edge outside reset
`define QTA_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("qta assertion failed");

// Consequent must hold in the cycle after the antecedent
`define QTA_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("qta assertion failed");

`endif

// ===== hw/rtl/qta_pkg.sv =====
// ----------------------------------------------------------------------------
// qta_pkg
// Types, constants and the arctangent table of the twist angle core.
// ----------------------------------------------------------------------------
package qta_pkg;

  localparam int FIELD_W         = 16;
  localparam int ML_W            = 10;
  localparam int ANGLE_FRAC_BITS = 13;
  localparam int ROUND_SH        = 30 - ANGLE_FRAC_BITS;
  localparam int FIFO_DEPTH      = 4;
  localparam int SQRT_STEPS      = 32;
  localparam int NORM_STAGES     = 6;
  localparam int CORDIC_STEPS    = 31;
  localparam int VX_W            = 49;
  localparam int VY_W            = 48;
  localparam int CW              = 52;
  localparam int ZW              = 35;

  localparam logic signed [ZW-1:0] Q30_PI      = 35'sd3373259426;
  localparam logic signed [ZW-1:0] Q30_HALF_PI = 35'sd1686629713;
  localparam logic signed [ZW-1:0] Q30_TWO_PI  = 35'sd6746518852;

  // One request handed from the front end to the angle unit
  typedef struct packed {
    logic signed [VX_W-1:0] vx;
    logic [VY_W-1:0]        vy;
    logic                   dpos;
    logic                   degen;
  } qta_job_t;

  function automatic logic signed [ZW-1:0] atan_entry(input int idx);
    logic signed [ZW-1:0] v;
    unique case (idx)
      0: v = 35'sd843314857;
      1: v = 35'sd497837829;
      2: v = 35'sd263043837;
      3: v = 35'sd133525159;
      4: v = 35'sd67021687;
      5: v = 35'sd33543516;
      6: v = 35'sd16775851;
      7: v = 35'sd8388437;
      8: v = 35'sd4194283;
      9: v = 35'sd2097149;
      default: v = ZW'(36'sd1 <<< (30 - idx));
    endcase
    return v;
  endfunction

endpackage

// ===== hw/rtl/qta_rot_if.sv =====
// ----------------------------------------------------------------------------
// qta_rot_if
// Request channel: quaternion and roll axis, valid/ready handshake.
// ----------------------------------------------------------------------------
interface qta_rot_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] rot_x;
  logic signed [15:0] rot_y;
  logic signed [15:0] rot_z;
  logic signed [15:0] rot_w;
  logic signed [15:0] axis_x;
  logic signed [15:0] axis_y;
  logic signed [15:0] axis_z;

  modport source (output valid, rot_x, rot_y, rot_z, rot_w, axis_x, axis_y, axis_z,
                  input ready);
  modport sink   (input valid, rot_x, rot_y, rot_z, rot_w, axis_x, axis_y, axis_z,
                  output ready);
endinterface

// ===== hw/rtl/qta_angle_if.sv =====
// ----------------------------------------------------------------------------
// qta_angle_if
// Result channel: twist angle and degenerate flag, valid/ready handshake.
// ----------------------------------------------------------------------------
interface qta_angle_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] twist_angle;
  logic               degenerate;

  modport source (output valid, twist_angle, degenerate, input ready);
  modport sink   (input valid, twist_angle, degenerate, output ready);
endinterface

// ===== hw/rtl/qta_front.sv =====
// ----------------------------------------------------------------------------
// qta_front
// Dot product, axis length, degenerate test and pipelined square root.
// ----------------------------------------------------------------------------
module qta_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [qta_pkg::ML_W-1:0]   min_length_i,
  qta_rot_if.sink                    in_i,
  output qta_pkg::qta_job_t          job_o,
  output logic                       job_valid_o,
  input  logic                       job_ready_i
);

  typedef struct packed {
    logic signed [15:0] qw;
    logic [31:0]        adot;
    logic               dpos;
    logic               n2z;
    logic               degen;
    logic [63:0]        rem;
    logic [31:0]        root;
  } sq_t;

  logic adv;
  logic acc;

  // stage 1: products
  logic               v1_q;
  logic signed [31:0] px_q, py_q, pz_q;
  logic [30:0]        ax2_q, ay2_q, az2_q, w2_1_q;
  logic signed [15:0] qw1_q;
  logic signed [31:0] sqx, sqy, sqz, sqw;

  // stage 2: sums
  logic               v2_q;
  logic [31:0]        n2_2_q, adot2_q;
  logic               dpos2_q, n2z2_q;
  logic [30:0]        w2_2_q;
  logic signed [15:0] qw2_q;
  logic signed [33:0] dot_d;
  logic [19:0]        m2;

  // stage 3: degenerate test products
  logic               v3_q;
  logic [63:0]        a2_q;
  logic [62:0]        wn_q;
  logic [51:0]        mn_q;
  logic               w2le_q;
  logic [31:0]        n2_3_q, adot3_q;
  logic               dpos3_q, n2z3_q;
  logic signed [15:0] qw3_q;

  // square root chain
  sq_t  sq_q  [0:qta_pkg::SQRT_STEPS];
  logic sqv_q [0:qta_pkg::SQRT_STEPS];

  qta_pkg::qta_job_t job_q;
  logic              jv_q;

  assign adv         = !jv_q || job_ready_i;
  assign acc         = in_i.valid && adv;
  assign in_i.ready  = adv;
  assign job_o       = job_q;
  assign job_valid_o = jv_q;

  assign sqx = in_i.axis_x * in_i.axis_x;
  assign sqy = in_i.axis_y * in_i.axis_y;
  assign sqz = in_i.axis_z * in_i.axis_z;
  assign sqw = in_i.rot_w * in_i.rot_w;
  assign dot_d = 34'(px_q) + 34'(py_q) + 34'(pz_q);
  assign m2 = 20'(min_length_i) * 20'(min_length_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      jv_q <= 1'b0;
    end else if (adv) begin
      v1_q <= acc;
      v2_q <= v1_q;
      v3_q <= v2_q;
      jv_q <= sqv_q[qta_pkg::SQRT_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      px_q   <= in_i.rot_x * in_i.axis_x;
      py_q   <= in_i.rot_y * in_i.axis_y;
      pz_q   <= in_i.rot_z * in_i.axis_z;
      ax2_q  <= sqx[30:0];
      ay2_q  <= sqy[30:0];
      az2_q  <= sqz[30:0];
      w2_1_q <= sqw[30:0];
      qw1_q  <= in_i.rot_w;

      n2_2_q  <= 32'(ax2_q) + 32'(ay2_q) + 32'(az2_q);
      adot2_q <= dot_d[33] ? 32'(-dot_d) : dot_d[31:0];
      dpos2_q <= !dot_d[33] && (dot_d != '0);
      n2z2_q  <= (ax2_q == '0) && (ay2_q == '0) && (az2_q == '0);
      w2_2_q  <= w2_1_q;
      qw2_q   <= qw1_q;

      a2_q    <= 64'(adot2_q) * 64'(adot2_q);
      wn_q    <= 63'(w2_2_q) * 63'(n2_2_q);
      mn_q    <= 52'(m2) * 52'(n2_2_q);
      w2le_q  <= w2_2_q <= 31'(m2);
      n2_3_q  <= n2_2_q;
      adot3_q <= adot2_q;
      dpos3_q <= dpos2_q;
      n2z3_q  <= n2z2_q;
      qw3_q   <= qw2_q;
    end
  end

  // square root entry: degenerate verdict and radicand n2 << 32
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sqv_q[0] <= 1'b0;
    end else if (adv) begin
      sqv_q[0] <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sq_q[0].qw    <= qw3_q;
      sq_q[0].adot  <= adot3_q;
      sq_q[0].dpos  <= dpos3_q;
      sq_q[0].n2z   <= n2z3_q;
      sq_q[0].degen <= n2z3_q ? w2le_q
                              : (65'(a2_q) + 65'(wn_q) <= 65'(mn_q));
      sq_q[0].rem   <= {n2_3_q, 32'd0};
      sq_q[0].root  <= '0;
    end
  end

  // one result bit per stage, most significant first
  for (genvar k = 1; k <= qta_pkg::SQRT_STEPS; k++) begin : g_sqrt
    localparam int B = qta_pkg::SQRT_STEPS - k;
    logic [63:0] trial;
    logic        take;
    sq_t         nxt;

    assign trial = ({32'd0, sq_q[k-1].root} << (B + 1)) | (64'd1 << (2 * B));
    assign take  = sq_q[k-1].rem >= trial;

    always_comb begin
      nxt = sq_q[k-1];
      if (take) begin
        nxt.rem  = sq_q[k-1].rem - trial;
        nxt.root = sq_q[k-1].root | (32'd1 << B);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sqv_q[k] <= 1'b0;
      end else if (adv) begin
        sqv_q[k] <= sqv_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        sq_q[k] <= nxt;
      end
    end
  end

  // angle vector: (w * sqrt(n2 << 32), |dot| << 16), or (w, 0) for a zero axis
  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (sq_q[qta_pkg::SQRT_STEPS].n2z) begin
        job_q.vx <= qta_pkg::VX_W'(sq_q[qta_pkg::SQRT_STEPS].qw);
        job_q.vy <= '0;
      end else begin
        job_q.vx <= sq_q[qta_pkg::SQRT_STEPS].qw
                    * $signed({1'b0, sq_q[qta_pkg::SQRT_STEPS].root});
        job_q.vy <= {sq_q[qta_pkg::SQRT_STEPS].adot, 16'd0};
      end
      job_q.dpos  <= sq_q[qta_pkg::SQRT_STEPS].dpos;
      job_q.degen <= sq_q[qta_pkg::SQRT_STEPS].degen;
    end
  end

endmodule

// ===== hw/rtl/qta_queue.sv =====
// ----------------------------------------------------------------------------
// qta_queue
// Short request queue between the front end and the angle unit.
// ----------------------------------------------------------------------------
`include "quaternion_twist_angle_core_assert.svh"

module qta_queue #(
  parameter int DEPTH = qta_pkg::FIFO_DEPTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  qta_pkg::qta_job_t push_data_i,
  input  logic              push_valid_i,
  output logic              push_ready_o,
  output qta_pkg::qta_job_t pop_data_o,
  output logic              pop_valid_o,
  input  logic              pop_ready_i
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  qta_pkg::qta_job_t mem_q [DEPTH];
  logic [AW-1:0]     wp_q, wp_d, rp_q, rp_d;
  logic [NW-1:0]     cnt_q, cnt_d;
  logic              push, pop;

  assign push_ready_o = cnt_q != NW'(DEPTH);
  assign pop_valid_o  = cnt_q != '0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rp_q];

  always_comb begin
    wp_d  = wp_q;
    rp_d  = rp_q;
    cnt_d = cnt_q;
    if (push) begin
      wp_d = (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
    end
    if (pop) begin
      rp_d = (rp_q == AW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wp_q] <= push_data_i;
    end
  end

  `QTA_ASSERT_ALWAYS(a_cnt_bound, cnt_q <= NW'(DEPTH))
  `QTA_ASSERT_NEXT(a_push_grows, push && !pop, cnt_q == $past(cnt_q) + 1'b1)
  `QTA_ASSERT_NEXT(a_pop_shrinks, pop && !push, cnt_q == $past(cnt_q) - 1'b1)

endmodule

// ===== hw/rtl/qta_back.sv =====
// ----------------------------------------------------------------------------
// qta_back
// Quadrant fold, normalization, vectoring CORDIC, wrap and rounding.
// ----------------------------------------------------------------------------
module qta_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  qta_pkg::qta_job_t job_i,
  input  logic              job_valid_i,
  output logic              job_ready_o,
  qta_angle_if.source       out_o
);

  localparam int NST = 1 + qta_pkg::NORM_STAGES + qta_pkg::CORDIC_STEPS;

  typedef struct packed {
    logic signed [qta_pkg::CW-1:0] x;
    logic signed [qta_pkg::CW-1:0] y;
    logic signed [qta_pkg::ZW-1:0] z;
    logic                          dpos;
    logic                          degen;
  } cs_t;

  cs_t  st_q [0:NST-1];
  logic stv_q [0:NST-1];
  cs_t  fold;

  logic                          adv;
  logic                          wv_q;
  logic signed [qta_pkg::ZW-1:0] r_q, r_d, theta, mag, rnd;
  logic                          wdeg_q;
  logic                          ov_q;
  logic signed [15:0]            tw_q;
  logic                          dg_q;

  assign adv         = !ov_q || out_o.ready;
  assign job_ready_o = adv;

  // fold the left half plane onto the first quadrant
  always_comb begin
    fold.dpos  = job_i.dpos;
    fold.degen = job_i.degen;
    if (job_i.vx < 0) begin
      fold.x = $signed({4'd0, job_i.vy});
      fold.y = -qta_pkg::CW'(job_i.vx);
      fold.z = qta_pkg::Q30_HALF_PI;
    end else begin
      fold.x = qta_pkg::CW'(job_i.vx);
      fold.y = $signed({4'd0, job_i.vy});
      fold.z = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stv_q[0] <= 1'b0;
    end else if (adv) begin
      stv_q[0] <= job_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      st_q[0] <= fold;
    end
  end

  for (genvar j = 1; j < NST; j++) begin : g_stage
    cs_t nxt;

    if (j <= qta_pkg::NORM_STAGES) begin : g_norm
      // shift by K while the larger part stays below 2^47
      localparam int K = 32 >> (j - 1);
      logic small_v;
      assign small_v = ~|(st_q[j-1].x[qta_pkg::CW-1:47-K] | st_q[j-1].y[qta_pkg::CW-1:47-K]);
      always_comb begin
        nxt = st_q[j-1];
        if (small_v) begin
          nxt.x = st_q[j-1].x <<< K;
          nxt.y = st_q[j-1].y <<< K;
        end
      end
    end else begin : g_rot
      localparam int C = j - 1 - qta_pkg::NORM_STAGES;
      logic signed [qta_pkg::CW-1:0] dx, dy;
      assign dx = st_q[j-1].y >>> C;
      assign dy = st_q[j-1].x >>> C;
      always_comb begin
        nxt = st_q[j-1];
        if (st_q[j-1].y > 0) begin
          nxt.x = st_q[j-1].x + dx;
          nxt.y = st_q[j-1].y - dy;
          nxt.z = st_q[j-1].z + qta_pkg::atan_entry(C);
        end else begin
          nxt.x = st_q[j-1].x - dx;
          nxt.y = st_q[j-1].y + dy;
          nxt.z = st_q[j-1].z - qta_pkg::atan_entry(C);
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        stv_q[j] <= 1'b0;
      end else if (adv) begin
        stv_q[j] <= stv_q[j-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        st_q[j] <= nxt;
      end
    end
  end

  // wrap the doubled angle into (-pi, pi], negate unless the dot is positive
  assign theta = st_q[NST-1].z <<< 1;
  always_comb begin
    if (st_q[NST-1].dpos) begin
      r_d = (theta <= qta_pkg::Q30_PI) ? theta : theta - qta_pkg::Q30_TWO_PI;
    end else begin
      r_d = (theta >= qta_pkg::Q30_PI) ? qta_pkg::Q30_TWO_PI - theta : -theta;
    end
  end

  // round the magnitude half up, then restore the sign
  assign mag = r_q[qta_pkg::ZW-1] ? -r_q : r_q;
  assign rnd = (mag + (qta_pkg::ZW'(1) <<< (qta_pkg::ROUND_SH - 1))) >>> qta_pkg::ROUND_SH;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wv_q <= 1'b0;
      ov_q <= 1'b0;
    end else if (adv) begin
      wv_q <= stv_q[NST-1];
      ov_q <= wv_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      r_q    <= r_d;
      wdeg_q <= st_q[NST-1].degen;
      dg_q   <= wdeg_q;
      if (wdeg_q) begin
        tw_q <= '0;
      end else if (r_q[qta_pkg::ZW-1]) begin
        tw_q <= 16'(-rnd);
      end else begin
        tw_q <= rnd[15:0];
      end
    end
  end

  assign out_o.valid       = ov_q;
  assign out_o.twist_angle = tw_q;
  assign out_o.degenerate  = dg_q;

endmodule

// ===== hw/rtl/quaternion_twist_angle_core.sv =====
// ----------------------------------------------------------------------------
// quaternion_twist_angle_core
// Signed twist angle of a rotation quaternion about a roll axis.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries one request per handshake: quaternion rot_x..rot_w and roll
//   axis axis_x..axis_z, all signed Q1.14. out_o returns one result per
//   request, in order: twist_angle in radians times 2^13 and the degenerate
//   flag. cfg_we_i/cfg_wdata_i write min_length; write it only while idle.
//   Throughput is one request per cycle when nothing stalls. A request passes
//   through the front end (products, sums, degenerate products, degenerate
//   verdict, 32-stage square root, vector product), the queue, and the angle
//   unit (fold, 6 normalize stages, 31 CORDIC stages, wrap, rounding).
//   A stalled receiver freezes the angle unit; the queue absorbs front-end
//   output until full, then in_i.ready drops. Reset empties every stage and
//   clears min_length to 0.
// ----------------------------------------------------------------------------
module quaternion_twist_angle_core #(
  parameter int FIFO_DEPTH = qta_pkg::FIFO_DEPTH
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [qta_pkg::ML_W-1:0] cfg_wdata_i,
  qta_rot_if.sink                  in_i,
  qta_angle_if.source              out_o
);

  logic [qta_pkg::ML_W-1:0] min_length_q;
  qta_pkg::qta_job_t        f_job, b_job;
  logic                     f_valid, f_ready, b_valid, b_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_length_q <= '0;
    end else if (cfg_we_i) begin
      min_length_q <= cfg_wdata_i;
    end
  end

  qta_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .min_length_i (min_length_q),
    .in_i         (in_i),
    .job_o        (f_job),
    .job_valid_o  (f_valid),
    .job_ready_i  (f_ready)
  );

  qta_queue #(
    .DEPTH (FIFO_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_data_i  (f_job),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .pop_data_o   (b_job),
    .pop_valid_o  (b_valid),
    .pop_ready_i  (b_ready)
  );

  qta_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (b_job),
    .job_valid_i (b_valid),
    .job_ready_o (b_ready),
    .out_o       (out_o)
  );

endmodule

// ===== test/qta_tb_pkg.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// qta_tb_pkg
// Twist angle predictor for the quaternion twist angle core testbench.
// ----------------------------------------------------------------------------
package qta_tb_pkg;

  localparam longint PI_Q30      = 64'sd3373259426;
  localparam longint HALF_PI_Q30 = 64'sd1686629713;
  localparam int     ANGLE_FRAC  = 13;
  localparam int     ARC_STEPS   = 31;

  typedef struct {
    logic signed [15:0] rx, ry, rz, rw, ax, ay, az;
  } rot_req_t;

  typedef struct {
    logic signed [15:0] angle;
    logic               degen;
  } twist_res_t;

  function automatic longint arc_step_angle(input int i);
    longint t[10] = '{843314857, 497837829, 263043837, 133525159, 67021687,
                      33543516, 16775851, 8388437, 4194283, 2097149};
    if (i < 10) return t[i];
    return 64'sd1 << (30 - i);
  endfunction

  // floor division by a power of two
  function automatic longint floor_shr(input longint v, input int s);
    return v >>> s;
  endfunction

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // atan2(y, x) in Q30 for y >= 0
  function automatic longint vector_angle(input longint x, input longint y);
    longint z, t, dx, dy;
    z = 0;
    if (x < 0) begin
      t = x;
      x = y;
      y = -t;
      z = HALF_PI_Q30;
    end
    while (x < (64'sd1 << 46) && y < (64'sd1 << 46)) begin
      x = x <<< 1;
      y = y <<< 1;
    end
    for (int i = 0; i < ARC_STEPS; i++) begin
      dx = floor_shr(y, i);
      dy = floor_shr(x, i);
      if (y > 0) begin
        x += dx; y -= dy; z += arc_step_angle(i);
      end else begin
        x -= dx; y += dy; z -= arc_step_angle(i);
      end
    end
    return z;
  endfunction

  function automatic twist_res_t predict_twist(input rot_req_t q,
                                               input logic [9:0] min_len);
    twist_res_t o;
    longint qx, qy, qz, qw, ax, ay, az, dotp, vx, vy, theta, r, mag;
    longint unsigned n2, m2, w2, adot;
    logic degen, dpos;
    int sh;
    qx = q.rx; qy = q.ry; qz = q.rz; qw = q.rw;
    ax = q.ax; ay = q.ay; az = q.az;
    sh = 30 - ANGLE_FRAC;
    n2 = ax * ax + ay * ay + az * az;
    dotp = qx * ax + qy * ay + qz * az;
    m2 = longint'(min_len) * longint'(min_len);
    w2 = qw * qw;
    adot = dotp < 0 ? -dotp : dotp;
    if (n2 == 0) begin
      degen = w2 <= m2;
      dpos = 1'b0;
      vx = qw;
      vy = 0;
    end else begin
      // products wrap at 64 bits exactly as unsigned arithmetic does
      degen = adot * adot + w2 * n2 <= m2 * n2;
      dpos = dotp > 0;
      vx = qw * longint'(int_sqrt(n2 << 32));
      vy = longint'(adot << 16);
    end
    o.angle = '0;
    o.degen = degen;
    if (degen) return o;
    theta = 2 * vector_angle(vx, vy);
    if (dpos) r = theta <= PI_Q30 ? theta : theta - 2 * PI_Q30;
    else r = theta >= PI_Q30 ? 2 * PI_Q30 - theta : -theta;
    mag = r < 0 ? -r : r;
    mag = (mag + (64'sd1 << (sh - 1))) >>> sh;
    o.angle = 16'(r < 0 ? -mag : mag);
    return o;
  endfunction

endpackage

// ===== test/quaternion_twist_angle_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// quaternion_twist_angle_core_tb
// Self-checking bench: directed table plus random requests with random stalls,
// each result compared against its table entry or a fixed point predictor.
// ----------------------------------------------------------------------------
module quaternion_twist_angle_core_tb;

  localparam int     N_RANDOM    = 1400;
  localparam int     DRAIN_CYC   = 120;
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct {
    qta_tb_pkg::rot_req_t   req;
    logic                   known;
    qta_tb_pkg::twist_res_t res;
  } dir_row_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_we_i = 1'b0;
  logic [9:0]             cfg_wdata_i = '0;
  logic [9:0]             min_len_q = '0;
  logic                   out_idle_en = 1'b1;
  longint                 cycle_cnt = 0;
  int                     mism_cnt = 0;
  int                     res_cnt = 0;
  int                     degen_cnt = 0;
  qta_tb_pkg::twist_res_t angle_q[$];
  dir_row_t               dir_rows[$];

  qta_rot_if   rot_ch ();
  qta_angle_if ang_ch ();

  quaternion_twist_angle_core uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_i       (rot_ch),
    .out_o      (ang_ch)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    rot_ch.valid = 1'b0;
    {rot_ch.rot_x, rot_ch.rot_y, rot_ch.rot_z, rot_ch.rot_w} = '0;
    {rot_ch.axis_x, rot_ch.axis_y, rot_ch.axis_z} = '0;
    ang_ch.ready = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("** quaternion_twist_angle_core: FAILED **");
      $finish;
    end
  end

  // result side: random stalls, compare against the oldest expectation
  always @(posedge clk_i) begin
    qta_tb_pkg::twist_res_t e;
    if (rst_ni && ang_ch.valid && ang_ch.ready) begin
      res_cnt <= res_cnt + 1;
      if (angle_q.size() == 0) begin
        mism_cnt <= mism_cnt + 1;
        if (mism_cnt < 10) $display("unexpected result angle=%0d", ang_ch.twist_angle);
      end else begin
        e = angle_q.pop_front();
        if (e.degen) degen_cnt <= degen_cnt + 1;
        if (e.angle !== ang_ch.twist_angle || e.degen !== ang_ch.degenerate) begin
          mism_cnt <= mism_cnt + 1;
          if (mism_cnt < 10)
            $display("mismatch: expected angle=%0d degen=%0b, got angle=%0d degen=%0b",
                     e.angle, e.degen, ang_ch.twist_angle, ang_ch.degenerate);
        end
      end
    end
    ang_ch.ready <= rst_ni && !(out_idle_en && $urandom_range(99) < 25);
  end

  function automatic qta_tb_pkg::rot_req_t mk_req(input int rx, ry, rz, rw, ax, ay, az);
    qta_tb_pkg::rot_req_t r;
    r.rx = 16'(rx); r.ry = 16'(ry); r.rz = 16'(rz); r.rw = 16'(rw);
    r.ax = 16'(ax); r.ay = 16'(ay); r.az = 16'(az);
    return r;
  endfunction

  task automatic add_row(input qta_tb_pkg::rot_req_t r, input logic known,
                         input int ang, input logic dg);
    dir_row_t d;
    d.req = r; d.known = known; d.res.angle = 16'(ang); d.res.degen = dg;
    dir_rows.insert(dir_rows.size(), d);
  endtask

  function automatic qta_tb_pkg::rot_req_t rand_req();
    qta_tb_pkg::rot_req_t r;
    int k;
    r = mk_req($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    k = $urandom_range(9);
    // in half the cases quaternion parts within +-1.0, some tiny or zero axes
    if (k < 5) begin
      r.rx = 16'($signed($urandom_range(32768)) - 16384);
      r.ry = 16'($signed($urandom_range(32768)) - 16384);
      r.rz = 16'($signed($urandom_range(32768)) - 16384);
      r.rw = 16'($signed($urandom_range(32768)) - 16384);
    end
    if (k == 6) {r.ax, r.ay, r.az} = '0;
    if (k == 7) begin
      r.ax = 16'($signed($urandom_range(8)) - 4);
      r.ay = 16'($signed($urandom_range(8)) - 4);
      r.az = 16'($signed($urandom_range(8)) - 4);
    end
    if (k == 8) begin
      r.rw = 16'($signed($urandom_range(2000)) - 1000);
      r.rx = 16'($signed($urandom_range(600)) - 300);
    end
    return r;
  endfunction

  // send one request, holding it until accepted
  task automatic send_req(input qta_tb_pkg::rot_req_t r, input logic use_idle);
    while (use_idle && $urandom_range(99) < 25) begin
      rot_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    rot_ch.valid  <= 1'b1;
    rot_ch.rot_x  <= r.rx; rot_ch.rot_y  <= r.ry;
    rot_ch.rot_z  <= r.rz; rot_ch.rot_w  <= r.rw;
    rot_ch.axis_x <= r.ax; rot_ch.axis_y <= r.ay; rot_ch.axis_z <= r.az;
    angle_q.insert(angle_q.size(), qta_tb_pkg::predict_twist(r, min_len_q));
    @(posedge clk_i);
    while (!rot_ch.ready) @(posedge clk_i);
  endtask

  task automatic drain_and_set(input logic [9:0] ml);
    rot_ch.valid <= 1'b0;
    while (angle_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= ml;
    min_len_q    = ml;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    logic [9:0] ml_set[5] = '{10'd0, 10'd1023, 10'd300, 10'd1023, 10'd0};
    qta_tb_pkg::twist_res_t want;
    logic       idle_on;
    int         n_phase;
    // rows with a known result: zero axis, identity, quarter turns, degenerate
    add_row(mk_req(0, 0, 0, 16384, 0, 0, 0), 1'b1, 0, 1'b0);
    add_row(mk_req(0, 0, 0, 0, 0, 0, 0), 1'b1, 0, 1'b1);
    add_row(mk_req(0, 0, 0, 0, 16384, 0, 0), 1'b1, 0, 1'b1);
    // half turns land on the wrap edge, so their sign comes from the predictor
    add_row(mk_req(16384, 0, 0, 0, 16384, 0, 0), 1'b0, 0, 1'b0);
    add_row(mk_req(-16384, 0, 0, 0, 16384, 0, 0), 1'b0, 0, 1'b0);
    add_row(mk_req(0, 0, 0, -16384, 0, 0, 0), 1'b0, 0, 1'b0);
    add_row(mk_req(0, 16384, 0, 16384, 0, 16384, 0), 1'b1, 12868, 1'b0);
    add_row(mk_req(0, 0, -16384, 16384, 0, 0, 16384), 1'b1, -12868, 1'b0);
    add_row(mk_req(0, 0, 0, 16384, 16384, 16384, 16384), 1'b1, 0, 1'b0);
    // extremes of every field, checked by the predictor
    add_row(mk_req(-32768, -32768, -32768, -32768, -32768, -32768, -32768), 0, 0, 0);
    add_row(mk_req(32767, 32767, 32767, 32767, 32767, 32767, 32767), 0, 0, 0);
    add_row(mk_req(32767, -32768, 32767, -32768, -32768, 32767, -32768), 0, 0, 0);
    add_row(mk_req(-32768, 0, 0, 1, -32768, 0, 0), 0, 0, 0);
    add_row(mk_req(1, 0, 0, -32768, 1, 0, 0), 0, 0, 0);
    add_row(mk_req(-1, 0, 0, -32768, 1, 0, 0), 0, 0, 0);
    add_row(mk_req(5000, 3000, -2000, 9000, 1, 1, 1), 0, 0, 0);
    add_row(mk_req(-5000, 3000, 2000, -9000, 0, 0, -3), 0, 0, 0);

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      send_req(dir_rows[i].req, 1'b0);
      if (dir_rows[i].known) begin
        want = angle_q[$];
        if (want.angle !== dir_rows[i].res.angle || want.degen !== dir_rows[i].res.degen)
          $display("note: table row %0d differs from predictor", i);
        angle_q[$] = dir_rows[i].res;
      end
    end

    // configuration phases, one with idling switched off on both sides
    n_phase = $size(ml_set);
    for (int p = 0; p < n_phase; p++) begin
      drain_and_set(ml_set[p]);
      idle_on = (p != 2);
      out_idle_en <= idle_on;
      if (p == 1 || p == 3) begin
        // a few degenerate-edge rows around the threshold
        send_req(mk_req(0, 0, 0, int'(ml_set[p]), 0, 0, 0), 1'b0);
        send_req(mk_req(0, 0, 0, int'(ml_set[p]) + 1, 0, 0, 0), 1'b0);
        send_req(mk_req(int'(ml_set[p]), 0, 0, 0, 16384, 0, 0), 1'b0);
      end
      for (int i = 0; i < N_RANDOM / n_phase; i++)
        send_req(rand_req(), idle_on);
      out_idle_en <= 1'b1;
    end

    rot_ch.valid <= 1'b0;
    while (angle_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);
    $display("covered %0d results (%0d degenerate) over %0d min_length settings",
             res_cnt, degen_cnt, n_phase + 1);
    $display("mismatches: %0d", mism_cnt);
    if (mism_cnt == 0 && angle_q.size() == 0)
      $display("** quaternion_twist_angle_core: PASSED **");
    else
      $display("** quaternion_twist_angle_core: FAILED **");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/qta_pkg.sv
hw/rtl/qta_rot_if.sv
hw/rtl/qta_angle_if.sv
hw/rtl/qta_front.sv
hw/rtl/qta_queue.sv
hw/rtl/qta_back.sv
hw/rtl/quaternion_twist_angle_core.sv
test/qta_tb_pkg.sv
test/quaternion_twist_angle_core_tb.sv
